>>> rtl/library_map_line_checker_macros.svh
// ----------------------------------------------------------------------------
// Library map line checker assertion macros
// Concurrent assertion wrappers shared by the checker RTL.
// ----------------------------------------------------------------------------
`ifndef LIBRARY_MAP_LINE_CHECKER_MACROS_SVH
`define LIBRARY_MAP_LINE_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LMLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmlc assertion failed");
// next-cycle implication
`define LMLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmlc assertion failed");
`else
`define LMLC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LMLC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/lmlc_pkg.sv
// ----------------------------------------------------------------------------
// Library map line checker package
// Shared types, character codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lmlc_pkg;

   localparam int HIST_LEN = 16;

   // character codes
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_S    = 8'h73;
   localparam logic [7:0] CHAR_O    = 8'h6F;
   localparam logic [7:0] CHAR_NL   = 8'h0A;

   // last character sits in the low byte, matching the newest history byte
   localparam logic [8*HIST_LEN-1:0] ANON_MARKER = "00000000 00:00 0";

   // register indexes
   localparam logic [3:0] CSR_FIRST_NAME      = 4'd0;
   localparam logic [3:0] CSR_FIRST_NAME_LEN  = 4'd1;
   localparam logic [3:0] CSR_SECOND_NAME     = 4'd2;
   localparam logic [3:0] CSR_SECOND_NAME_LEN = 4'd3;

   // register reset values ("libc" and "ld")
   localparam logic [63:0] FIRST_NAME_RESET      = 64'd1667393900;
   localparam logic [3:0]  FIRST_NAME_LEN_RESET  = 4'd4;
   localparam logic [63:0] SECOND_NAME_RESET     = 64'd25708;
   localparam logic [3:0]  SECOND_NAME_LEN_RESET = 4'd2;

   // verdict codes
   localparam logic [1:0] VERDICT_CLEAN    = 2'd0;
   localparam logic [1:0] VERDICT_DETECTED = 2'd1;
   localparam logic [1:0] VERDICT_NONE     = 2'd2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       stream_end;
      logic       is_digit;
      logic       is_dash;
      logic       is_dot;
      logic       is_s;
      logic       is_o;
      logic       is_nl;
   } byte_class_type;

   typedef struct packed {
      logic [63:0] first_name;
      logic [3:0]  first_name_len;
      logic [63:0] second_name;
      logic [3:0]  second_name_len;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/lmlc_front.sv
// ----------------------------------------------------------------------------
// Library map line checker front end
// Accepts text bytes and tags each with its character class for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lmlc_front (
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_text_byte,
   input  wire logic                    req_stream_end,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output lmlc_pkg::byte_class_type     push_data
);

   always_comb begin
      push_data.text_byte  = req_text_byte;
      push_data.stream_end = req_stream_end;
      push_data.is_digit   = (req_text_byte >= lmlc_pkg::CHAR_ZERO) &&
                             (req_text_byte <= lmlc_pkg::CHAR_NINE);
      push_data.is_dash    = (req_text_byte == lmlc_pkg::CHAR_DASH);
      push_data.is_dot     = (req_text_byte == lmlc_pkg::CHAR_DOT);
      push_data.is_s       = (req_text_byte == lmlc_pkg::CHAR_S);
      push_data.is_o       = (req_text_byte == lmlc_pkg::CHAR_O);
      push_data.is_nl      = (req_text_byte == lmlc_pkg::CHAR_NL);
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

>>> rtl/lmlc_queue.sv
// ----------------------------------------------------------------------------
// Library map line checker request queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "library_map_line_checker_macros.svh"

module lmlc_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire lmlc_pkg::byte_class_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output lmlc_pkg::byte_class_type      out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lmlc_pkg::byte_class_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != CW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `LMLC_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(DEPTH))
   `LMLC_ASSERT_NXT(a_push_only_grows, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + CW'(1))
   `LMLC_ASSERT_IMP(a_ptrs_meet_empty, clock, reset, cnt_ff == '0, rd_ptr_ff == wr_ptr_ff)

endmodule

`default_nettype wire

>>> rtl/lmlc_back.sv
// ----------------------------------------------------------------------------
// Library map line checker back end
// Keeps the byte history, matches names and marker, runs the tail checks
// and decides the verdict at each chunk end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "library_map_line_checker_macros.svh"

module lmlc_back #(
   parameter int CHUNK_MAX      = 255,
   parameter int NAME_MAX_BYTES = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lmlc_pkg::cfg_type        cfg,
   input  wire logic                     q_valid,
   output logic                          q_ready,
   input  wire lmlc_pkg::byte_class_type q_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_verdict,
   output logic [15:0]                   rsp_chunk_number
);

   localparam int PW = $clog2(CHUNK_MAX + 1);
   localparam int HL = lmlc_pkg::HIST_LEN;

   typedef enum logic [3:0] {
      T_SEARCH,
      T_DASH,
      T_D1_FIRST,
      T_D1,
      T_D2_FIRST,
      T_D2,
      T_EXP_S,
      T_EXP_O,
      T_EXP_NL,
      T_PASS,
      T_FAIL
   } tail_type;

   typedef logic [HL-1:0][7:0] hist_type;

   hist_type      hist_ff, hist_new;
   logic [PW-1:0] pos_ff, pos_in, count;
   tail_type      first_tail_ff, first_tail_in, first_tail_new;
   tail_type      second_tail_ff, second_tail_in, second_tail_new;
   logic          seen_ff, seen_in;
   logic          decided_ff, decided_in;
   logic          anon_ff, anon_in, anon_new;
   logic [15:0]   chunk_cnt_ff, chunk_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_verdict_ff, verdict_new;
   logic [15:0]   rsp_chunk_ff;
   logic          adv, emit, chunk_end, decide_now;
   logic          first_hit, second_hit;

   function automatic logic name_hit(input logic [63:0] name, input logic [3:0] len,
                                     input logic [PW-1:0] cnt, input hist_type h);
      logic [3:0] eff;
      logic       hit;
      logic       ok;
      eff = (len > 4'(NAME_MAX_BYTES)) ? 4'(NAME_MAX_BYTES) : len;
      hit = 1'b0;
      for (int l = 1; l <= NAME_MAX_BYTES; l++) begin
         ok = (cnt >= PW'(l));
         for (int j = 0; j < NAME_MAX_BYTES; j++) begin
            for (int k = 0; k < NAME_MAX_BYTES; k++) begin
               if ((j + k + 1 == l) && (h[j] != name[8*k +: 8])) begin
                  ok = 1'b0;
               end
            end
         end
         if (eff == 4'(l)) begin
            hit = ok;
         end
      end
      return hit;
   endfunction

   function automatic tail_type tail_next(input tail_type st,
                                          input lmlc_pkg::byte_class_type cl);
      tail_type nx;
      unique case (st)
         T_DASH:     nx = cl.is_dash ? T_D1_FIRST : T_FAIL;
         T_D1_FIRST: nx = cl.is_digit ? T_D1 : T_FAIL;
         T_D1:       nx = cl.is_digit ? T_D1 : (cl.is_dot ? T_D2_FIRST : T_FAIL);
         T_D2_FIRST: nx = cl.is_digit ? T_D2 : T_FAIL;
         T_D2:       nx = cl.is_digit ? T_D2 : (cl.is_dot ? T_EXP_S : T_FAIL);
         T_EXP_S:    nx = cl.is_s ? T_EXP_O : T_FAIL;
         T_EXP_O:    nx = cl.is_o ? T_EXP_NL : T_FAIL;
         T_EXP_NL:   nx = cl.is_nl ? T_PASS : T_FAIL;
         default:    nx = T_FAIL;
      endcase
      return nx;
   endfunction

   // an empty name matches at once, so the tail starts on this byte
   function automatic tail_type tail_step(input tail_type st, input logic [3:0] len,
                                          input logic hit,
                                          input lmlc_pkg::byte_class_type cl);
      tail_type nx;
      if (st == T_SEARCH && len == 4'd0) begin
         nx = tail_next(T_DASH, cl);
      end else if (st == T_SEARCH) begin
         nx = hit ? T_DASH : T_SEARCH;
      end else begin
         nx = tail_next(st, cl);
      end
      return nx;
   endfunction

   // hold only a request that gives a verdict while the previous one waits
   assign q_ready = !emit || !rsp_valid_ff || rsp_ready;
   assign adv     = q_valid && q_ready;

   always_comb begin
      hist_new[0] = q_data.text_byte;
      for (int i = 1; i < HL; i++) begin
         hist_new[i] = hist_ff[i-1];
      end
      count      = pos_ff + PW'(1);
      first_hit  = name_hit(cfg.first_name, cfg.first_name_len, count, hist_new);
      second_hit = name_hit(cfg.second_name, cfg.second_name_len, count, hist_new);
      first_tail_new  = tail_step(first_tail_ff, cfg.first_name_len, first_hit, q_data);
      second_tail_new = tail_step(second_tail_ff, cfg.second_name_len, second_hit, q_data);
      anon_new  = anon_ff || ((count >= PW'(HL)) && (hist_new == lmlc_pkg::ANON_MARKER));
      chunk_end = q_data.is_nl || (count >= PW'(CHUNK_MAX)) || q_data.stream_end;

      seen_in        = seen_ff;
      decided_in     = decided_ff;
      pos_in         = count;
      first_tail_in  = first_tail_new;
      second_tail_in = second_tail_new;
      anon_in        = anon_new;
      chunk_cnt_in   = chunk_cnt_ff;
      decide_now     = 1'b0;
      verdict_new    = lmlc_pkg::VERDICT_NONE;
      emit           = 1'b0;

      if (decided_ff) begin
         // ignore bytes until the end of the stream
         pos_in         = pos_ff;
         first_tail_in  = first_tail_ff;
         second_tail_in = second_tail_ff;
         anon_in        = anon_ff;
      end else if (chunk_end) begin
         if (first_tail_new == T_PASS) begin
            seen_in = 1'b1;
         end else if (seen_ff) begin
            if (second_tail_new == T_PASS) begin
               decide_now  = 1'b1;
               verdict_new = lmlc_pkg::VERDICT_CLEAN;
            end else if (!anon_new) begin
               decide_now  = 1'b1;
               verdict_new = lmlc_pkg::VERDICT_DETECTED;
            end
         end
         decided_in = decide_now;
         emit       = decide_now || q_data.stream_end;
         if (!decide_now && chunk_cnt_ff != '1) begin
            chunk_cnt_in = chunk_cnt_ff + 16'd1;
         end
         pos_in         = '0;
         first_tail_in  = T_SEARCH;
         second_tail_in = T_SEARCH;
         anon_in        = 1'b0;
      end

      if (q_data.stream_end) begin
         seen_in        = 1'b0;
         decided_in     = 1'b0;
         chunk_cnt_in   = '0;
         pos_in         = '0;
         first_tail_in  = T_SEARCH;
         second_tail_in = T_SEARCH;
         anon_in        = 1'b0;
      end
   end

   always_comb begin
      if (adv && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff        <= 1'b0;
         decided_ff     <= 1'b0;
         pos_ff         <= '0;
         first_tail_ff  <= T_SEARCH;
         second_tail_ff <= T_SEARCH;
         anon_ff        <= 1'b0;
         chunk_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            seen_ff        <= seen_in;
            decided_ff     <= decided_in;
            pos_ff         <= pos_in;
            first_tail_ff  <= first_tail_in;
            second_tail_ff <= second_tail_in;
            anon_ff        <= anon_in;
            chunk_cnt_ff   <= chunk_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && !decided_ff) begin
         hist_ff <= hist_new;
      end
      if (adv && emit) begin
         rsp_verdict_ff <= verdict_new;
         rsp_chunk_ff   <= chunk_cnt_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_chunk_number = rsp_chunk_ff;

   `LMLC_ASSERT_IMP(a_decided_needs_seen, clock, reset, decided_ff, seen_ff)
   `LMLC_ASSERT_IMP(a_pos_in_chunk, clock, reset, 1'b1, pos_ff < PW'(CHUNK_MAX))
   `LMLC_ASSERT_NXT(a_end_clears, clock, reset, adv && q_data.stream_end, !decided_ff && !seen_ff && chunk_cnt_ff == '0 && pos_ff == '0)
   `LMLC_ASSERT_NXT(a_ignored_quiet, clock, reset, adv && decided_ff && !q_data.stream_end, rsp_valid_ff == ($past(rsp_valid_ff) && !$past(rsp_ready)))

endmodule

`default_nettype wire

>>> rtl/library_map_line_checker.sv
// ----------------------------------------------------------------------------
// Library map line checker
// Scans memory-map text for the configured library lines and reports
// whether a foreign mapping follows the first library.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one text byte per request, req_stream_end on the final byte.
//   rsp_*  : at most one verdict per stream (clean, detected or none) with
//            the index of the deciding chunk.
//   csr_*  : register writes (index 0..3), always ready; write while idle.
// Throughput is one byte per cycle unless a verdict waits on a stalled
// receiver; the back end matches both names, the anonymous-mapping marker
// and both tail checks combinationally against a 16-byte history register.
// A request passes through the request queue, then through the match and
// decision logic into the response register.
// While a verdict waits on a stalled receiver the back end keeps scanning
// and holds only a request that would give the next verdict; the front
// keeps taking requests until the queue (QUEUE_DEPTH entries) fills, then
// drops req_ready.
// Reset restores the register defaults and clears the stream state; there
// is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module library_map_line_checker #(
   parameter int CHUNK_MAX      = 255,
   parameter int NAME_MAX_BYTES = 8,
   parameter int QUEUE_DEPTH    = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_stream_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_verdict,
   output logic [15:0]      rsp_chunk_number,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   lmlc_pkg::cfg_type        cfg_ff;
   lmlc_pkg::byte_class_type push_data, pop_data;
   logic                     push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_name      <= lmlc_pkg::FIRST_NAME_RESET;
         cfg_ff.first_name_len  <= lmlc_pkg::FIRST_NAME_LEN_RESET;
         cfg_ff.second_name     <= lmlc_pkg::SECOND_NAME_RESET;
         cfg_ff.second_name_len <= lmlc_pkg::SECOND_NAME_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lmlc_pkg::CSR_FIRST_NAME:      cfg_ff.first_name      <= csr_wdata;
            lmlc_pkg::CSR_FIRST_NAME_LEN:  cfg_ff.first_name_len  <= csr_wdata[3:0];
            lmlc_pkg::CSR_SECOND_NAME:     cfg_ff.second_name     <= csr_wdata;
            lmlc_pkg::CSR_SECOND_NAME_LEN: cfg_ff.second_name_len <= csr_wdata[3:0];
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   lmlc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_stream_end (req_stream_end),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   lmlc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   lmlc_back #(
      .CHUNK_MAX      (CHUNK_MAX),
      .NAME_MAX_BYTES (NAME_MAX_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (pop_valid),
      .q_ready          (pop_ready),
      .q_data           (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_chunk_number (rsp_chunk_number)
   );

endmodule

`default_nettype wire
